FILE: rtl/core/rbc_pkg.sv
// Shared types, register codes and constants for the RSSI burst capture controller.
package rbc_pkg;

    localparam int MaxChannels = 16;
    localparam int MinEdges    = 4;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 16;

    localparam logic [CfgIndexW-1:0] CfgThreshold  = 3'd0;
    localparam logic [CfgIndexW-1:0] CfgEndGap     = 3'd1;
    localparam logic [CfgIndexW-1:0] CfgCaptureMax = 3'd2;
    localparam logic [CfgIndexW-1:0] CfgHoldoff    = 3'd3;
    localparam logic [CfgIndexW-1:0] CfgDwell      = 3'd4;
    localparam logic [CfgIndexW-1:0] CfgChanCount  = 3'd5;
    localparam logic [CfgIndexW-1:0] CfgMode       = 3'd6;

    localparam logic [1:0] ModeOok  = 2'd0;
    localparam logic [1:0] ModeFsk  = 2'd1;
    localparam logic [1:0] ModeDual = 2'd2;

    localparam logic signed [11:0] SuspectLevel = -12'sd750;
    localparam logic signed [11:0] PeakFloor    = -12'sd1300;

    typedef struct packed {
        logic signed [11:0] threshold;
        logic [15:0]        end_gap_ms;
        logic [15:0]        max_len_ms;
        logic [15:0]        holdoff_ms;
        logic [15:0]        dwell_len_ms;
        logic [4:0]         channel_count;
        logic [1:0]         capture_mode;
        logic               mode_write;
        logic [1:0]         mode_wdata;
    } rbc_cfg_t;

    typedef struct packed {
        logic [3:0]         channel_index;
        logic               channel_changed;
        logic               modulation_fsk;
        logic               capture_begin;
        logic               capturing;
        logic               capture_end;
        logic               capture_kept;
        logic signed [11:0] peak_tenths_dbm;
        logic               fsk_suspect;
        logic [31:0]        hit_count;
    } rbc_result_t;

endpackage

FILE: rtl/core/rbc_cfg.sv
// Configuration register bank written through the index/data write channel.
module rbc_cfg
    import rbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data,
    output rbc_cfg_t             cfg
);

    logic signed [11:0] threshold_reg;
    logic [15:0]        end_gap_reg;
    logic [15:0]        capture_max_reg;
    logic [15:0]        holdoff_reg;
    logic [15:0]        dwell_reg;
    logic [4:0]         chan_count_reg;
    logic [1:0]         mode_reg;
    logic               wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= -12'sd800;
            end_gap_reg     <= 16'd120;
            capture_max_reg <= 16'd1500;
            holdoff_reg     <= 16'd500;
            dwell_reg       <= 16'd80;
            chan_count_reg  <= 5'd1;
            mode_reg        <= ModeOok;
        end
        else if (wr)
        begin
            unique case (cfg_index)
                CfgThreshold:  threshold_reg   <= signed'(cfg_data[11:0]);
                CfgEndGap:     end_gap_reg     <= cfg_data;
                CfgCaptureMax: capture_max_reg <= cfg_data;
                CfgHoldoff:    holdoff_reg     <= cfg_data;
                CfgDwell:      dwell_reg       <= cfg_data;
                CfgChanCount:  chan_count_reg  <= cfg_data[4:0];
                CfgMode:       mode_reg        <= cfg_data[1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        cfg.threshold     = threshold_reg;
        cfg.end_gap_ms    = end_gap_reg;
        cfg.max_len_ms    = capture_max_reg;
        cfg.holdoff_ms    = holdoff_reg;
        cfg.dwell_len_ms  = dwell_reg;
        cfg.channel_count = chan_count_reg;
        cfg.capture_mode  = mode_reg;
        cfg.mode_write    = wr && (cfg_index == CfgMode);
        cfg.mode_wdata    = cfg_data[1:0];
    end

endmodule

FILE: rtl/core/rbc_core.sv
// Capture, hold-off, dual-mode and channel sweep state with its one-sample update logic.
module rbc_core
    import rbc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  rbc_cfg_t           cfg,
    input  logic               accept,
    input  logic signed [11:0] rssi_tenths_dbm,
    input  logic [31:0]        now_ms,
    input  logic               protocol_decoded,
    input  logic [12:0]        edge_count,
    output rbc_result_t        result
);

    localparam logic [4:0] CountCap = (MaxChannels > 31) ? 5'd31 : 5'(MaxChannels);

    logic               open_reg, open_next;
    logic [31:0]        cap_start_reg, cap_start_next;
    logic               quiet_reg, quiet_next;
    logic [31:0]        quiet_start_reg, quiet_start_next;
    logic signed [11:0] peak_reg, peak_next;
    logic               win_reg, win_next;
    logic [31:0]        win_start_reg, win_start_next;
    logic [3:0]         chan_reg, chan_next;
    logic               fsk_reg, fsk_next;
    logic               retry_reg, retry_next;
    logic               suspicion_reg, suspicion_next;
    logic               holdoff_reg, holdoff_next;
    logic [31:0]        until_reg, until_next;
    logic [31:0]        hits_reg, hits_next;

    logic        ignore;
    logic [31:0] holdoff_rem;
    logic        finish;
    logic        quiet_end;
    logic        begin_ev;
    logic        kept;
    logic        suspect;
    logic        changed;
    logic [4:0]  eff_count;
    logic [4:0]  chan_inc;

    assign holdoff_rem = until_reg - now_ms;
    assign chan_inc    = {1'b0, chan_reg} + 5'd1;

    always_comb
    begin
        if (cfg.channel_count == 5'd0)
            eff_count = 5'd1;
        else if (cfg.channel_count > CountCap)
            eff_count = CountCap;
        else
            eff_count = cfg.channel_count;
    end

    always_comb
    begin
        open_next        = open_reg;
        cap_start_next   = cap_start_reg;
        quiet_next       = quiet_reg;
        quiet_start_next = quiet_start_reg;
        peak_next        = peak_reg;
        win_next         = win_reg;
        win_start_next   = win_start_reg;
        chan_next        = chan_reg;
        fsk_next         = fsk_reg;
        retry_next       = retry_reg;
        suspicion_next   = suspicion_reg;
        holdoff_next     = holdoff_reg;
        until_next       = until_reg;
        hits_next        = hits_reg;
        ignore           = 1'b0;
        finish           = 1'b0;
        quiet_end        = 1'b0;
        begin_ev         = 1'b0;
        kept             = 1'b0;
        suspect          = 1'b0;
        changed          = 1'b0;

        if (holdoff_reg)
        begin
            if (holdoff_rem != 32'd0 && holdoff_rem <= {16'd0, cfg.holdoff_ms})
                ignore = 1'b1;
            else
                holdoff_next = 1'b0;
        end

        if (!ignore)
        begin
            if (!win_reg)
            begin
                win_next       = 1'b1;
                win_start_next = now_ms;
            end

            if (rssi_tenths_dbm >= cfg.threshold)
            begin
                if (!open_reg)
                begin
                    open_next      = 1'b1;
                    cap_start_next = now_ms;
                    peak_next      = rssi_tenths_dbm;
                    begin_ev       = 1'b1;
                end
                else if (rssi_tenths_dbm > peak_reg)
                begin
                    peak_next = rssi_tenths_dbm;
                end
                quiet_next = 1'b0;
            end
            else if (open_reg)
            begin
                quiet_next = 1'b1;
                if (!quiet_reg)
                    quiet_start_next = now_ms;
                if (now_ms - quiet_start_next >= {16'd0, cfg.end_gap_ms})
                begin
                    finish    = 1'b1;
                    quiet_end = 1'b1;
                end
            end

            if (!finish && open_next &&
                now_ms - cap_start_next >= {16'd0, cfg.max_len_ms})
                finish = 1'b1;

            if (finish)
            begin
                open_next  = 1'b0;
                quiet_next = 1'b0;
                if (edge_count >= 13'(MinEdges))
                begin
                    kept           = 1'b1;
                    suspect        = !protocol_decoded && (peak_next >= SuspectLevel) &&
                                     !fsk_reg;
                    suspicion_next = suspect;
                    hits_next      = hits_reg + 32'd1;
                end
                // Dual mode: a pending retry reverts to OOK, else a suspicion arms one.
                if (cfg.capture_mode == ModeDual)
                begin
                    if (retry_reg)
                    begin
                        retry_next = 1'b0;
                        fsk_next   = 1'b0;
                    end
                    else if (suspicion_next)
                    begin
                        retry_next = 1'b1;
                        fsk_next   = 1'b1;
                    end
                end
                if (quiet_end && cfg.holdoff_ms != 16'd0)
                begin
                    holdoff_next = 1'b1;
                    until_next   = now_ms + {16'd0, cfg.holdoff_ms};
                end
            end

            if (cfg.dwell_len_ms != 16'd0 &&
                now_ms - win_start_next >= {16'd0, cfg.dwell_len_ms})
            begin
                chan_next  = (chan_inc >= eff_count) ? 4'd0 : chan_inc[3:0];
                changed    = 1'b1;
                open_next  = 1'b0;
                quiet_next = 1'b0;
                win_next   = 1'b0;
                if (cfg.capture_mode == ModeDual && !retry_next)
                    fsk_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg        <= 1'b0;
            cap_start_reg   <= 32'd0;
            quiet_reg       <= 1'b0;
            quiet_start_reg <= 32'd0;
            peak_reg        <= PeakFloor;
            win_reg         <= 1'b0;
            win_start_reg   <= 32'd0;
            chan_reg        <= 4'd0;
            fsk_reg         <= 1'b0;
            retry_reg       <= 1'b0;
            suspicion_reg   <= 1'b0;
            holdoff_reg     <= 1'b0;
            until_reg       <= 32'd0;
            hits_reg        <= 32'd0;
        end
        else if (cfg.mode_write)
        begin
            fsk_reg   <= (cfg.mode_wdata == ModeFsk);
            retry_reg <= 1'b0;
        end
        else if (accept)
        begin
            open_reg        <= open_next;
            cap_start_reg   <= cap_start_next;
            quiet_reg       <= quiet_next;
            quiet_start_reg <= quiet_start_next;
            peak_reg        <= peak_next;
            win_reg         <= win_next;
            win_start_reg   <= win_start_next;
            chan_reg        <= chan_next;
            fsk_reg         <= fsk_next;
            retry_reg       <= retry_next;
            suspicion_reg   <= suspicion_next;
            holdoff_reg     <= holdoff_next;
            until_reg       <= until_next;
            hits_reg        <= hits_next;
        end
    end

    always_comb
    begin
        result.channel_index   = chan_next;
        result.channel_changed = changed;
        result.modulation_fsk  = fsk_next;
        result.capture_begin   = begin_ev;
        result.capturing       = open_next;
        result.capture_end     = finish;
        result.capture_kept    = kept;
        result.peak_tenths_dbm = peak_next;
        result.fsk_suspect     = suspect;
        result.hit_count       = hits_next;
    end

endmodule

FILE: rtl/core/rbc_outbuf.sv
// Result register with a skid stage so that a sample is taken while a result waits.
module rbc_outbuf
    import rbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rbc_result_t push_data,
    output logic        full,
    output logic        out_valid,
    input  logic        out_stall,
    output rbc_result_t out_data
);

    logic        main_valid_reg, main_valid_next;
    rbc_result_t main_reg, main_next;
    logic        skid_valid_reg, skid_valid_next;
    rbc_result_t skid_reg, skid_next;
    logic        pop;

    assign pop       = main_valid_reg & ~out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
            else
            begin
                main_valid_next = 1'b1;
                main_next       = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

FILE: rtl/core/rssi_burst_capture_controller.sv
// Each accepted sample transaction yields one result, registered in the result buffer.
// Throughput: one sample per cycle while sample_stall is low; the single-pass state update closes in the accept cycle.
// A two-entry result buffer keeps sample_stall low until both entries hold results.
// Reset clears all capture, sweep and hit state and loads the register defaults.
// Configuration writes complete in the cycle they are presented.
module rssi_burst_capture_controller
    import rbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  logic signed [11:0]   rssi_tenths_dbm,
    input  logic [31:0]          now_ms,
    input  logic                 protocol_decoded,
    input  logic [12:0]          edge_count,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [3:0]           channel_index,
    output logic                 channel_changed,
    output logic                 modulation_fsk,
    output logic                 capture_begin,
    output logic                 capturing,
    output logic                 capture_end,
    output logic                 capture_kept,
    output logic signed [11:0]   peak_tenths_dbm,
    output logic                 fsk_suspect,
    output logic [31:0]          hit_count
);

    rbc_cfg_t    cfg;
    rbc_result_t step_result;
    rbc_result_t out_result;
    logic        accept;
    logic        buf_full;

    assign sample_stall = buf_full;
    assign accept       = sample_valid & ~buf_full;

    rbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rbc_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .accept           (accept),
        .rssi_tenths_dbm  (rssi_tenths_dbm),
        .now_ms           (now_ms),
        .protocol_decoded (protocol_decoded),
        .edge_count       (edge_count),
        .result           (step_result)
    );

    rbc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_result),
        .full      (buf_full),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (out_result)
    );

    assign channel_index   = out_result.channel_index;
    assign channel_changed = out_result.channel_changed;
    assign modulation_fsk  = out_result.modulation_fsk;
    assign capture_begin   = out_result.capture_begin;
    assign capturing       = out_result.capturing;
    assign capture_end     = out_result.capture_end;
    assign capture_kept    = out_result.capture_kept;
    assign peak_tenths_dbm = out_result.peak_tenths_dbm;
    assign fsk_suspect     = out_result.fsk_suspect;
    assign hit_count       = out_result.hit_count;

endmodule

FILE: verif/rssi_burst_capture_controller_tb.sv
// Self-checking testbench for the RSSI burst capture controller with its own burst predictor.
`timescale 1ns / 100ps

module testbench;
    import rbc_pkg::*;

    localparam logic [1:0] ModeSpare = 2'd3;
    localparam int PaceNone  = 0;
    localparam int PaceFull  = 1;
    localparam int PaceLight = 2;
    localparam int CycleLimit = 600000;
    localparam int ReportLimit = 100;

    typedef struct packed {
        logic signed [11:0] rssi;
        logic [31:0]        now;
        logic               decoded;
        logic [12:0]        edges;
    } poll_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0]  cfg_data = '0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    logic signed [11:0]   rssi_tenths_dbm = '0;
    logic [31:0]          now_ms = '0;
    logic                 protocol_decoded = 1'b0;
    logic [12:0]          edge_count = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [3:0]           channel_index;
    logic                 channel_changed;
    logic                 modulation_fsk;
    logic                 capture_begin;
    logic                 capturing;
    logic                 capture_end;
    logic                 capture_kept;
    logic signed [11:0]   peak_tenths_dbm;
    logic                 fsk_suspect;
    logic [31:0]          hit_count;

    rssi_burst_capture_controller dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .rssi_tenths_dbm  (rssi_tenths_dbm),
        .now_ms           (now_ms),
        .protocol_decoded (protocol_decoded),
        .edge_count       (edge_count),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .channel_index    (channel_index),
        .channel_changed  (channel_changed),
        .modulation_fsk   (modulation_fsk),
        .capture_begin    (capture_begin),
        .capturing        (capturing),
        .capture_end      (capture_end),
        .capture_kept     (capture_kept),
        .peak_tenths_dbm  (peak_tenths_dbm),
        .fsk_suspect      (fsk_suspect),
        .hit_count        (hit_count)
    );

    // Register copies held by the predictor.
    logic signed [11:0] reg_threshold  = -12'sd800;
    logic [15:0]        reg_end_gap    = 16'd120;
    logic [15:0]        reg_cap_max    = 16'd1500;
    logic [15:0]        reg_holdoff    = 16'd500;
    logic [15:0]        reg_dwell      = 16'd80;
    logic [4:0]         reg_chan_count = 5'd1;
    logic [1:0]         reg_mode       = ModeOok;

    // Capture, sweep and hit state of the predictor.
    logic               cap_open     = 1'b0;
    logic [31:0]        cap_t0       = '0;
    logic               quiet_on     = 1'b0;
    logic [31:0]        quiet_t0     = '0;
    logic signed [11:0] peak_lvl     = PeakFloor;
    logic               win_open     = 1'b0;
    logic [31:0]        win_t0       = '0;
    logic [3:0]         chan         = '0;
    logic               fsk_on       = 1'b0;
    logic               retry_armed  = 1'b0;
    logic               prev_suspect = 1'b0;
    logic               hold_on      = 1'b0;
    logic [31:0]        hold_until   = '0;
    logic [31:0]        hits         = '0;

    poll_t       pending_polls[$];
    rbc_result_t expected_outcomes[$];

    int errors = 0;
    int polls_accepted = 0;
    int results_checked = 0;
    int settings_used = 0;
    int kept_total = 0;
    int suspect_total = 0;
    int channel_steps = 0;
    int polls_ignored = 0;
    int cycle_count = 0;
    int burst_budget = 0;
    logic [31:0] tick_ms = '0;

    int tx_pace = PaceNone;
    int rx_pace = PaceNone;
    int tx_gap = 0;
    int rx_wait = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_len = 0;
    int hold_left = 0;

    function automatic rbc_result_t predict_poll_outcome(input poll_t p);
        rbc_result_t r;
        logic [31:0] remaining;
        logic        ignored;
        logic        finish;
        logic        quiet_end;
        int unsigned span;
        int unsigned nxt;
        r = '0;
        ignored = 1'b0;
        if (hold_on) begin
            remaining = hold_until - p.now;
            if (remaining != 0 && remaining <= {16'd0, reg_holdoff})
                ignored = 1'b1;
            else
                hold_on = 1'b0;
        end
        if (ignored) begin
            polls_ignored++;
        end
        else begin
            if (!win_open) begin
                win_open = 1'b1;
                win_t0 = p.now;
            end
            finish = 1'b0;
            quiet_end = 1'b0;
            if (p.rssi >= reg_threshold) begin
                if (!cap_open) begin
                    cap_open = 1'b1;
                    cap_t0 = p.now;
                    peak_lvl = p.rssi;
                    r.capture_begin = 1'b1;
                end
                if (p.rssi > peak_lvl)
                    peak_lvl = p.rssi;
                quiet_on = 1'b0;
            end
            else if (cap_open) begin
                if (!quiet_on) begin
                    quiet_on = 1'b1;
                    quiet_t0 = p.now;
                end
                if (p.now - quiet_t0 >= {16'd0, reg_end_gap}) begin
                    finish = 1'b1;
                    quiet_end = 1'b1;
                end
            end
            if (!finish && cap_open && p.now - cap_t0 >= {16'd0, reg_cap_max})
                finish = 1'b1;
            if (finish) begin
                r.capture_end = 1'b1;
                cap_open = 1'b0;
                quiet_on = 1'b0;
                if (p.edges >= MinEdges) begin
                    r.capture_kept = 1'b1;
                    r.fsk_suspect = !p.decoded && peak_lvl >= SuspectLevel && !fsk_on;
                    prev_suspect = r.fsk_suspect;
                    hits = hits + 1;
                    kept_total++;
                    if (r.fsk_suspect)
                        suspect_total++;
                end
                // Dual mode: a pending retry is used up, otherwise a suspicion arms one.
                if (reg_mode == ModeDual) begin
                    if (retry_armed) begin
                        retry_armed = 1'b0;
                        fsk_on = 1'b0;
                    end
                    else if (prev_suspect) begin
                        retry_armed = 1'b1;
                        fsk_on = 1'b1;
                    end
                end
                if (quiet_end && reg_holdoff != 0) begin
                    hold_on = 1'b1;
                    hold_until = p.now + {16'd0, reg_holdoff};
                end
            end
            if (reg_dwell != 0 && p.now - win_t0 >= {16'd0, reg_dwell}) begin
                if (reg_chan_count == 0)
                    span = 1;
                else if (reg_chan_count > MaxChannels)
                    span = MaxChannels;
                else
                    span = reg_chan_count;
                nxt = chan + 1;
                if (nxt >= span)
                    nxt = 0;
                chan = 4'(nxt);
                r.channel_changed = 1'b1;
                cap_open = 1'b0;
                quiet_on = 1'b0;
                win_open = 1'b0;
                channel_steps++;
                if (reg_mode == ModeDual && !retry_armed)
                    fsk_on = 1'b0;
            end
        end
        r.channel_index = chan;
        r.modulation_fsk = fsk_on;
        r.capturing = cap_open;
        r.peak_tenths_dbm = peak_lvl;
        r.hit_count = hits;
        return r;
    endfunction

    function automatic int draw_wait(input int pace);
        case (pace)
            PaceNone: return 0;
            PaceFull: return $urandom_range(0, 18);
            default:  return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
        endcase
    endfunction

    function automatic logic signed [11:0] clamp_level(input int v);
        if (v > 2047)
            return 12'sd2047;
        if (v < -2048)
            return -12'sd2048;
        return 12'(v);
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            errors++;
            if (errors <= ReportLimit)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_outcomes.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Sample driver: predicts each accepted transaction, then presents the next one.
    always @(posedge clk) begin : sample_driver
        poll_t  nxt;
        logic   accepted;
        if (rst_n) begin
            accepted = sample_valid && !sample_stall;
            if (accepted) begin
                nxt.rssi = rssi_tenths_dbm;
                nxt.now = now_ms;
                nxt.decoded = protocol_decoded;
                nxt.edges = edge_count;
                expected_outcomes.push_back(predict_poll_outcome(nxt));
                polls_accepted++;
            end
            if (!sample_valid || accepted) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    sample_valid <= 1'b0;
                end
                else if (pending_polls.size() > 0) begin
                    nxt = pending_polls.pop_front();
                    rssi_tenths_dbm <= nxt.rssi;
                    now_ms <= nxt.now;
                    protocol_decoded <= nxt.decoded;
                    edge_count <= nxt.edges;
                    sample_valid <= 1'b1;
                    tx_gap = draw_wait(tx_pace);
                end
                else begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so that the sender keeps offering samples.
    always @(posedge clk) begin
        if (hold_req != hold_ack) begin
            hold_left <= hold_len;
            hold_ack <= hold_req;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk) begin : result_monitor
        rbc_result_t got;
        rbc_result_t want;
        logic        accepted;
        if (rst_n) begin
            accepted = result_valid && !result_stall;
            if (accepted) begin
                got.channel_index = channel_index;
                got.channel_changed = channel_changed;
                got.modulation_fsk = modulation_fsk;
                got.capture_begin = capture_begin;
                got.capturing = capturing;
                got.capture_end = capture_end;
                got.capture_kept = capture_kept;
                got.peak_tenths_dbm = peak_tenths_dbm;
                got.fsk_suspect = fsk_suspect;
                got.hit_count = hit_count;
                results_checked++;
                if (expected_outcomes.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with no sample outstanding, expected none, actual %h",
                             $time, got);
                end
                else begin
                    want = expected_outcomes.pop_front();
                    check_field("channel_index", want.channel_index, got.channel_index);
                    check_field("channel_changed", want.channel_changed, got.channel_changed);
                    check_field("modulation_fsk", want.modulation_fsk, got.modulation_fsk);
                    check_field("capture_begin", want.capture_begin, got.capture_begin);
                    check_field("capturing", want.capturing, got.capturing);
                    check_field("capture_end", want.capture_end, got.capture_end);
                    check_field("capture_kept", want.capture_kept, got.capture_kept);
                    check_field("peak_tenths_dbm", $signed(want.peak_tenths_dbm),
                                $signed(got.peak_tenths_dbm));
                    check_field("fsk_suspect", want.fsk_suspect, got.fsk_suspect);
                    check_field("hit_count", want.hit_count, got.hit_count);
                end
                rx_wait = draw_wait(rx_pace);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                result_stall <= 1'b1;
            end
            else begin
                result_stall <= (hold_left > 0);
            end
        end
    end

    task automatic wait_drained();
        while (pending_polls.size() != 0 || sample_valid || expected_outcomes.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CfgThreshold:  reg_threshold = val[11:0];
            CfgEndGap:     reg_end_gap = val;
            CfgCaptureMax: reg_cap_max = val;
            CfgHoldoff:    reg_holdoff = val;
            CfgDwell:      reg_dwell = val;
            CfgChanCount:  reg_chan_count = val[4:0];
            CfgMode:
            begin
                reg_mode = val[1:0];
                fsk_on = (val[1:0] == ModeFsk);
                retry_armed = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic load_settings(input int thr, gap, cap_max, hold, dwell, count, mode);
        write_reg(CfgThreshold, CfgDataW'(thr));
        write_reg(CfgEndGap, CfgDataW'(gap));
        write_reg(CfgCaptureMax, CfgDataW'(cap_max));
        write_reg(CfgHoldoff, CfgDataW'(hold));
        write_reg(CfgDwell, CfgDataW'(dwell));
        write_reg(CfgChanCount, CfgDataW'(count));
        write_reg(CfgMode, CfgDataW'(mode));
        settings_used++;
        @(negedge clk);
    endtask

    task automatic push_poll(input int lvl, input logic [31:0] at, input logic dec, input int edges);
        poll_t p;
        p.rssi = clamp_level(lvl);
        p.now = at;
        p.decoded = dec;
        p.edges = edges[12:0];
        pending_polls.push_back(p);
    endtask

    task automatic emit(input int lvl, input logic dec, input int edges, input int step_max);
        int step;
        step = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, step_max);
        if ($urandom_range(0, 40) == 0)
            step = step * 25;
        tick_ms = tick_ms + step;
        push_poll(lvl, tick_ms, dec, edges);
        burst_budget--;
    endtask

    function automatic int level_near(input logic above);
        int thr;
        thr = reg_threshold;
        return above ? thr + $urandom_range(0, 400) : thr - 1 - $urandom_range(0, 300);
    endfunction

    // Mostly well-formed bursts: a quiet lead-in, a strong stretch with the odd dip,
    // then a quiet tail; now and then a sample with arbitrary field values.
    task automatic push_bursts(input int n, input int step_max);
        int   edges;
        int   rate;
        logic dec;
        logic [31:0] jump;
        burst_budget = n;
        while (burst_budget > 0) begin
            if ($urandom_range(0, 24) == 0) begin
                jump = $urandom;
                push_poll($urandom_range(0, 4095) - 2048, jump, 1'($urandom_range(0, 1)),
                          $urandom_range(0, 8191));
                if ($urandom_range(0, 1) == 0)
                    tick_ms = jump;
                burst_budget--;
            end
            else begin
                repeat ($urandom_range(0, 4))
                    emit(level_near(1'b0), 1'($urandom_range(0, 1)), $urandom_range(0, 3),
                         step_max);
                dec = ($urandom_range(0, 3) == 0);
                rate = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 900);
                edges = 0;
                repeat ($urandom_range(1, 12)) begin
                    edges += $urandom_range(0, rate);
                    if (edges > 4096)
                        edges = 4096;
                    emit(level_near($urandom_range(0, 6) != 0), dec, edges, step_max);
                end
                repeat ($urandom_range(1, 6))
                    emit(level_near(1'b0), dec, edges, step_max);
            end
        end
    endtask

    task automatic run_phase(input int thr, gap, cap_max, hold, dwell, count, mode,
                             input int n, step_max);
        wait_drained();
        tx_pace = $urandom_range(PaceNone, PaceLight);
        rx_pace = $urandom_range(PaceNone, PaceLight);
        load_settings(thr, gap, cap_max, hold, dwell, count, mode);
        push_bursts(n, step_max);
    endtask

    initial begin : stimulus
        int ph;
        int step_max;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        tx_pace = PaceLight;
        rx_pace = PaceLight;

        // Register defaults: field extremes, then a dwell expiry that drops an open capture.
        push_poll(-2048, 32'd0, 1'b0, 0);
        push_poll(2047, 32'd5, 1'b1, 4096);
        push_poll(-1300, 32'd80, 1'b0, 8191);
        wait_drained();

        // Short gaps in dual mode: suspicion, FSK retry, hold-off and its boundary,
        // a short capture, a forced end and the -75 dBm edge on either side.
        load_settings(-800, 10, 50, 20, 0, 1, ModeDual);
        push_poll(-2048, 32'd1000, 1'b0, 0);
        push_poll(-700, 32'd1001, 1'b0, 0);
        push_poll(2047, 32'd1002, 1'b0, 8191);
        push_poll(-801, 32'd1003, 1'b0, 6);
        push_poll(-900, 32'd1013, 1'b0, 6);
        push_poll(-500, 32'd1020, 1'b1, 9);
        push_poll(-500, 32'd1033, 1'b0, 0);
        push_poll(-1000, 32'd1040, 1'b0, 2);
        push_poll(-1000, 32'd1050, 1'b0, 2);
        push_poll(-600, 32'd1100, 1'b1, 0);
        push_poll(-600, 32'd1150, 1'b1, 4);
        push_poll(-750, 32'd1151, 1'b0, 0);
        push_poll(-900, 32'd1152, 1'b0, 5);
        push_poll(-900, 32'd1162, 1'b0, 5);
        push_poll(-751, 32'd1200, 1'b0, 0);
        push_poll(-1300, 32'd1201, 1'b0, 4);
        push_poll(-1300, 32'd1211, 1'b0, 4);
        push_poll(-751, 32'd1300, 1'b0, 0);
        push_poll(-1300, 32'd1301, 1'b0, 7);
        push_poll(-1300, 32'd1311, 1'b0, 7);
        wait_drained();
        // A zero maximum length opens and closes a capture on one sample.
        write_reg(CfgCaptureMax, 16'd0);
        @(negedge clk);
        push_poll(-500, 32'd1400, 1'b0, 5);
        tick_ms = 32'd2000;

        // The sender runs flat out while the receiver holds off for a long stretch.
        run_phase(-800, 15, 120, 25, 0, 1, ModeDual, 300, 6);
        tx_pace = PaceNone;
        hold_len = 150;
        hold_req++;

        run_phase(-1300, 0, 1, 0, 60, 16, ModeFsk, 180, 8);
        run_phase(0, 65535, 65535, 65535, 65535, 0, ModeSpare, 120, 20000);
        run_phase(-800, 120, 1500, 500, 80, 1, ModeOok, 150, 30);
        run_phase(2047, 5, 40, 10, 0, 1, ModeDual, 60, 4);
        run_phase(-2048, 5, 40, 10, 200, 5, ModeOok, 60, 4);

        for (ph = 0; ph < 4; ph++) begin
            step_max = $urandom_range(2, 12);
            if (ph == 1)
                tick_ms = 32'hFFFF_F800;
            run_phase(-$urandom_range(0, 1300), $urandom_range(0, 40), $urandom_range(0, 300),
                      $urandom_range(0, 60),
                      ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(50, 600),
                      $urandom_range(0, 31), $urandom_range(ModeOok, ModeSpare), 100, step_max);
            // The sender pauses until every outstanding result has come back.
            wait_drained();
            push_bursts(100, step_max);
        end

        wait_drained();
        if (expected_outcomes.size() != 0) begin
            errors++;
            $display("%0t ns: %0d expected results never arrived", $time, expected_outcomes.size());
        end
        $display("Run covered %0d samples under %0d register settings, %0d results checked.",
                 polls_accepted, settings_used, results_checked);
        $display("Captures kept %0d, FSK suspicions %0d, channel steps %0d, hold-off skips %0d.",
                 kept_total, suspect_total, channel_steps, polls_ignored);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: rssi_burst_capture_controller.f
rtl/core/rbc_pkg.sv
rtl/core/rbc_cfg.sv
rtl/core/rbc_core.sv
rtl/core/rbc_outbuf.sv
rtl/core/rssi_burst_capture_controller.sv
verif/rssi_burst_capture_controller_tb.sv
